@@ hw/rtl/tzcd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tzcd_pkg: shared types and constants of the triac zero-cross dimmer
// Field widths, configuration register indexes and their reset values.
// ----------------------------------------------------------------------------
package tzcd_pkg;

    localparam int LEVEL_W = 8;
    localparam int TICKS_W = 16;
    localparam int COUNT_W = 20;
    localparam int STROKE_W = 32;
    localparam int ACC_W = 9;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 20;
    localparam int PROD_W = LEVEL_W + TICKS_W;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_SKIP_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_CYCLE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GLITCH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_FIRE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_FIRE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_TIMEOUT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_ON = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_OFF = 3'd7;

    // Reset values of the configuration registers.
    localparam logic [TICKS_W-1:0] RST_HALF_CYCLE = 16'd10000;
    localparam logic [TICKS_W-1:0] RST_GLITCH = 16'd4000;
    localparam logic [TICKS_W-1:0] RST_MIN_FIRE = 16'd200;
    localparam logic [TICKS_W-1:0] RST_MAX_FIRE = 16'd9500;
    localparam logic [COUNT_W-1:0] RST_SYNC_TIMEOUT = 20'd100000;
    localparam logic [LEVEL_W-1:0] RST_FULL_ON = 8'd250;
    localparam logic [LEVEL_W-1:0] RST_FULL_OFF = 8'd2;

    localparam logic [COUNT_W-1:0] TICK_SAT = 20'hFFFFF;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 8'd255;
    localparam logic [ACC_W-1:0] SKIP_RANGE = 9'd255;

    // Payload that follows a tick down the delay pipeline.
    typedef struct packed {
        logic                 crossing_edge;
        logic [LEVEL_W-1:0]   power_level;
    } tick_t;

endpackage

@@ hw/rtl/tzcd_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tzcd_tick_if / tzcd_result_if: valid/ready channels of the dimmer
// One beat is one timebase tick in, or one gate result out.
// ----------------------------------------------------------------------------
interface tzcd_tick_if;
    logic                          valid;
    logic                          ready;
    logic                          crossing_edge;
    logic [tzcd_pkg::LEVEL_W-1:0]  power_level;

    modport source (output valid, output crossing_edge, output power_level, input ready);
    modport sink (input valid, input crossing_edge, input power_level, output ready);
endinterface

interface tzcd_result_if;
    logic                          valid;
    logic                          ready;
    logic                          gate_on;
    logic                          sync_ok;
    logic [tzcd_pkg::STROKE_W-1:0] stroke_count;

    modport source (output valid, output gate_on, output sync_ok, output stroke_count,
                    input ready);
    modport sink (input valid, input gate_on, input sync_ok, input stroke_count,
                  output ready);
endinterface

@@ hw/rtl/triac_zero_cross_dimmer_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triac_zero_cross_dimmer_top: phase-angle and pulse-skip triac dimmer
// Tracks mains zero crossings and drives the triac gate one tick at a time.
// ----------------------------------------------------------------------------
// The block takes one tick beat every clock cycle while the result side does
// not stall, and returns one result beat per tick, in order. Each tick passes
// through the firing-delay datapath: an 8 x 16 bit multiply, a divide by
// 255 done as a reciprocal shift-and-add, its one-step correction, and the
// min/max clamp; then comes the state update, which writes the output
// register. Any stall on the result side holds the whole pipeline, and the
// tick side is ready whenever the output register is empty or being taken.
// Configuration registers may only be written while no tick is in flight.
module triac_zero_cross_dimmer_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [tzcd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tzcd_pkg::CFG_DATA_W-1:0]   cfg_data,
    tzcd_tick_if.sink                         tick,
    tzcd_result_if.source                     result
);
    import tzcd_pkg::*;

    // Configuration registers.
    logic                 cfg_mode_reg;
    logic [TICKS_W-1:0]   cfg_half_reg;
    logic [TICKS_W-1:0]   cfg_glitch_reg;
    logic [TICKS_W-1:0]   cfg_min_reg;
    logic [TICKS_W-1:0]   cfg_max_reg;
    logic [COUNT_W-1:0]   cfg_timeout_reg;
    logic [LEVEL_W-1:0]   cfg_on_reg;
    logic [LEVEL_W-1:0]   cfg_off_reg;

    // Delay pipeline.
    logic                 en;
    logic                 v1_reg, v2_reg, v3_reg, v4_reg;
    tick_t                s1_reg, s2_reg, s3_reg, s4_reg;
    logic [PROD_W-1:0]    prod1_reg;
    logic [PROD_W-1:0]    prod2_reg;
    logic [TICKS_W:0]     qest2_reg;
    logic [TICKS_W-1:0]   q3_reg;
    logic [TICKS_W-1:0]   d4_reg;

    logic [PROD_W-1:0]    prod_calc;
    logic [PROD_W+15:0]   recip_sum;
    logic [PROD_W:0]      qest_x255;
    logic                 qest_high;
    logic [TICKS_W:0]     q_fix;
    logic [TICKS_W-1:0]   d_clamp;

    // Dimmer state.
    logic [COUNT_W-1:0]   tsc_reg, tsc_next, tsc_inc;
    logic [TICKS_W-1:0]   fire_delay_reg, fire_delay_next, fire_dec;
    logic                 fire_pending_reg, fire_pending_next;
    logic                 gate_reg, gate_next;
    logic [ACC_W-1:0]     skip_acc_reg, skip_acc_next, skip_sum;
    logic                 second_half_reg, second_half_next;
    logic [STROKE_W-1:0]  stroke_cnt_reg, stroke_cnt_next;
    logic                 sync_next;
    logic                 accepted;
    logic                 out_valid_reg;
    logic                 out_sync_reg;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_mode_reg    <= 1'b0;
            cfg_half_reg    <= RST_HALF_CYCLE;
            cfg_glitch_reg  <= RST_GLITCH;
            cfg_min_reg     <= RST_MIN_FIRE;
            cfg_max_reg     <= RST_MAX_FIRE;
            cfg_timeout_reg <= RST_SYNC_TIMEOUT;
            cfg_on_reg      <= RST_FULL_ON;
            cfg_off_reg     <= RST_FULL_OFF;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_PULSE_SKIP_MODE: cfg_mode_reg    <= cfg_data[0];
                CFG_HALF_CYCLE:      cfg_half_reg    <= cfg_data[TICKS_W-1:0];
                CFG_GLITCH:          cfg_glitch_reg  <= cfg_data[TICKS_W-1:0];
                CFG_MIN_FIRE:        cfg_min_reg     <= cfg_data[TICKS_W-1:0];
                CFG_MAX_FIRE:        cfg_max_reg     <= cfg_data[TICKS_W-1:0];
                CFG_SYNC_TIMEOUT:    cfg_timeout_reg <= cfg_data[COUNT_W-1:0];
                CFG_FULL_ON:         cfg_on_reg      <= cfg_data[LEVEL_W-1:0];
                CFG_FULL_OFF:        cfg_off_reg     <= cfg_data[LEVEL_W-1:0];
                default:             cfg_mode_reg    <= cfg_mode_reg;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Firing-delay datapath
    // ------------------------------------------------------------------
    assign en = !out_valid_reg || result.ready;
    assign tick.ready = en;

    assign prod_calc = PROD_W'(LEVEL_MAX - tick.power_level) * PROD_W'(cfg_half_reg);

    // 0x8081 / 2^23 is slightly above 1/255, so the estimate is the true
    // quotient or one more; the following stage takes the excess off.
    assign recip_sum = {prod1_reg, 15'd0} + {8'd0, prod1_reg, 7'd0}
                     + {16'd0, prod1_reg};
    assign qest_x255 = {qest2_reg, 8'd0} - {8'd0, qest2_reg};
    assign qest_high = qest_x255 > {1'b0, prod2_reg};
    assign q_fix = qest2_reg - {{TICKS_W{1'b0}}, qest_high};

    always_comb
    begin
        priority if (q3_reg < cfg_min_reg)
            d_clamp = cfg_min_reg;
        else if (q3_reg > cfg_max_reg)
            d_clamp = cfg_max_reg;
        else
            d_clamp = q3_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= tick.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg    <= '{crossing_edge: tick.crossing_edge, power_level: tick.power_level};
            prod1_reg <= prod_calc;
            s2_reg    <= s1_reg;
            prod2_reg <= prod1_reg;
            qest2_reg <= recip_sum[PROD_W+15:23];
            s3_reg    <= s2_reg;
            q3_reg    <= q_fix[TICKS_W-1:0];
            s4_reg    <= s3_reg;
            d4_reg    <= d_clamp;
        end
    end

    // ------------------------------------------------------------------
    // Tick state update
    // ------------------------------------------------------------------
    assign tsc_inc = (tsc_reg != TICK_SAT) ? tsc_reg + COUNT_W'(1) : tsc_reg;
    assign accepted = s4_reg.crossing_edge && (tsc_inc >= COUNT_W'(cfg_glitch_reg));
    assign skip_sum = skip_acc_reg + ACC_W'(s4_reg.power_level);
    assign fire_dec = fire_delay_reg - TICKS_W'(1);

    always_comb
    begin
        tsc_next          = accepted ? '0 : tsc_inc;
        fire_delay_next   = fire_delay_reg;
        fire_pending_next = fire_pending_reg;
        gate_next         = gate_reg;
        skip_acc_next     = skip_acc_reg;
        second_half_next  = second_half_reg;
        stroke_cnt_next   = stroke_cnt_reg;

        if (accepted)
        begin
            fire_pending_next = 1'b0;
            fire_delay_next   = '0;
            if (cfg_mode_reg)
            begin
                second_half_next = !second_half_reg;
                // The decision falls on the crossing that closes a full cycle.
                if (second_half_reg)
                begin
                    if (skip_sum >= SKIP_RANGE)
                    begin
                        skip_acc_next   = skip_sum - SKIP_RANGE;
                        gate_next       = 1'b1;
                        stroke_cnt_next = stroke_cnt_reg + STROKE_W'(1);
                    end
                    else
                    begin
                        skip_acc_next = skip_sum;
                        gate_next     = 1'b0;
                    end
                end
            end
            else if (s4_reg.power_level >= cfg_on_reg)
                gate_next = 1'b1;
            else
            begin
                gate_next = 1'b0;
                if (s4_reg.power_level > cfg_off_reg)
                begin
                    if (d4_reg == '0)
                        gate_next = 1'b1;
                    else
                    begin
                        fire_delay_next   = d4_reg;
                        fire_pending_next = 1'b1;
                    end
                end
            end
        end
        else if (fire_pending_reg)
        begin
            fire_delay_next = fire_dec;
            if (fire_dec == '0)
            begin
                fire_pending_next = 1'b0;
                gate_next         = 1'b1;
            end
        end

        sync_next = tsc_next < cfg_timeout_reg;
        // Without sync the gate simply follows the requested level.
        if (!sync_next)
            gate_next = s4_reg.power_level > cfg_off_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tsc_reg          <= '0;
            fire_delay_reg   <= '0;
            fire_pending_reg <= 1'b0;
            gate_reg         <= 1'b0;
            skip_acc_reg     <= '0;
            second_half_reg  <= 1'b0;
            stroke_cnt_reg   <= '0;
            out_valid_reg    <= 1'b0;
            out_sync_reg     <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= v4_reg;
            if (v4_reg)
            begin
                tsc_reg          <= tsc_next;
                fire_delay_reg   <= fire_delay_next;
                fire_pending_reg <= fire_pending_next;
                gate_reg         <= gate_next;
                skip_acc_reg     <= skip_acc_next;
                second_half_reg  <= second_half_next;
                stroke_cnt_reg   <= stroke_cnt_next;
                out_sync_reg     <= sync_next;
            end
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.gate_on      = gate_reg;
    assign result.sync_ok      = out_sync_reg;
    assign result.stroke_count = stroke_cnt_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_pending_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        fire_pending_reg |-> (fire_delay_reg != '0))
        else $error("fire pending with a zero delay count");

    a_acc_range: assert property (@(posedge clk) disable iff (!rst_n)
        skip_acc_reg < SKIP_RANGE)
        else $error("pulse-skip accumulator out of range");

    a_stroke_step: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (stroke_cnt_reg == $past(stroke_cnt_reg)
                  || stroke_cnt_reg == $past(stroke_cnt_reg) + STROKE_W'(1)))
        else $error("stroke counter moved by more than one");

    a_stroke_phase: assert property (@(posedge clk) disable iff (!rst_n)
        !cfg_mode_reg |=> $stable(stroke_cnt_reg))
        else $error("stroke counter advanced in phase-angle mode");

    a_nosync_gate: assert property (@(posedge clk) disable iff (!rst_n)
        (en && v4_reg && !sync_next) |=> (gate_reg == $past(s4_reg.power_level > cfg_off_reg)))
        else $error("gate does not follow level while sync is lost");

endmodule
